FILE: design/quadratic_root_solver_defines.svh
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define QRS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never hold outside reset
`define QRS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: design/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

   localparam int EPS_W = 40;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_A_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;

   localparam logic [EPS_W-1:0] EPS_RESET = 40'd4295;

   typedef struct packed {
      logic signed [23:0] coef_a;
      logic signed [23:0] coef_b;
      logic signed [23:0] coef_c;
   } qrs_req_type;

   typedef struct packed {
      logic [1:0]         root_count;
      logic signed [31:0] first_root;
      logic signed [31:0] second_root;
      logic [1:0]         status;
   } qrs_rsp_type;

endpackage

`default_nettype wire

FILE: design/qrs_sqrt.sv
`default_nettype none

module qrs_sqrt #(
   parameter int TAG_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [63:0]       in_x,
   input  wire logic [TAG_W-1:0]  in_tag,
   output logic                   out_valid,
   output logic [31:0]            out_root,
   output logic [TAG_W-1:0]       out_tag
);

   localparam int STAGES = 32;
   localparam int REM_W  = 35;

   logic [REM_W-1:0] rem_ff  [STAGES];
   logic [31:0]      root_ff [STAGES];
   logic [63:0]      x_ff    [STAGES];
   logic [TAG_W-1:0] tag_ff  [STAGES];
   logic             v_ff    [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [REM_W-1:0] rem_p;
      logic [31:0]      root_p;
      logic [63:0]      x_p;
      logic [TAG_W-1:0] tag_p;
      logic             v_p;
      logic [REM_W-1:0] cat;
      logic [REM_W-1:0] trial;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [31:0]      root_in;

      if (i == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign x_p    = in_x;
         assign tag_p  = in_tag;
         assign v_p    = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign x_p    = x_ff[i-1];
         assign tag_p  = tag_ff[i-1];
         assign v_p    = v_ff[i-1];
      end

      always_comb begin
         cat     = {rem_p[REM_W-3:0], x_p[63:62]};
         trial   = REM_W'({root_p, 2'b01});
         ge      = (cat >= trial);
         rem_in  = ge ? (cat - trial) : cat;
         root_in = {root_p[30:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         x_ff[i]    <= {x_p[61:0], 2'b00};
         tag_ff[i]  <= tag_p;
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_p;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];

endmodule

`default_nettype wire

FILE: design/qrs_div.sv
`default_nettype none

module qrs_div #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 24,
   parameter int TAG_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [TAG_W-1:0]  in_tag,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [TAG_W-1:0]       out_tag
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];
   logic             v_ff   [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_p;
      logic [NUM_W-1:0] num_p;
      logic [NUM_W-1:0] quo_p;
      logic [DEN_W-1:0] den_p;
      logic [TAG_W-1:0] tag_p;
      logic             v_p;
      logic [DEN_W:0]   cat;
      logic             ge;
      logic [DEN_W:0]   diff;

      if (i == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = in_num;
         assign quo_p = '0;
         assign den_p = in_den;
         assign tag_p = in_tag;
         assign v_p   = in_valid;
      end else begin : g_next
         assign rem_p = rem_ff[i-1];
         assign num_p = num_ff[i-1];
         assign quo_p = quo_ff[i-1];
         assign den_p = den_ff[i-1];
         assign tag_p = tag_ff[i-1];
         assign v_p   = v_ff[i-1];
      end

      always_comb begin
         cat  = {rem_p, num_p[NUM_W-1]};
         ge   = (cat >= {1'b0, den_p});
         diff = cat - {1'b0, den_p};
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
         num_ff[i] <= {num_p[NUM_W-2:0], 1'b0};
         quo_ff[i] <= {quo_p[NUM_W-2:0], ge};
         den_ff[i] <= den_p;
         tag_ff[i] <= tag_p;
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_p;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

`default_nettype wire

FILE: design/quadratic_root_solver.sv
// Real roots of a*x^2+b*x+c from signed Q8.16 coefficients, as signed Q16.16 roots
// rounded toward zero. The block takes one item every cycle (busy stays low) and puts
// each result on the ports as a one-cycle rsp_valid pulse; the receiver cannot stall,
// so it must take every result in that cycle. Each item passes through the 32-stage
// square root and the 42-stage quotient pipelines. csr_wr_data is the discriminant
// threshold; the user must write it only while no item is in flight. This is not enforced.
`default_nettype none
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire qrs_pkg::qrs_req_type        req_item,
   output logic                             rsp_valid,
   output qrs_pkg::qrs_rsp_type             rsp_item,
   input  wire logic                        csr_wr_en,
   input  wire logic [qrs_pkg::EPS_W-1:0]   csr_wr_data
);

   localparam int SQ_TAG_W = 51;
   localparam int NUM_W    = 42;

   logic [qrs_pkg::EPS_W-1:0] eps_ff;

   qrs_pkg::qrs_req_type req_ff;
   logic                 v0_ff;

   logic signed [47:0] bb_in, ac_in, bb1_ff, ac1_ff;
   logic signed [23:0] a1_ff, b1_ff;
   logic               v1_ff;

   logic signed [49:0] d_in;
   logic [49:0]        mag;
   logic               az_in, one_in;
   logic [1:0]         cnt_in;
   logic [63:0]        x_in;
   logic [63:0]        x2_ff;
   logic signed [23:0] a2_ff, b2_ff;
   logic [1:0]         cnt2_ff;
   logic               az2_ff, v2_ff;

   logic                sq_valid;
   logic [31:0]         sq_root;
   logic [SQ_TAG_W-1:0] sq_tag;
   logic signed [23:0]  a3, b3;
   logic [1:0]          cnt3;
   logic                az3;

   logic signed [33:0]      bext, nb, sx, n_plus, n_minus;
   logic signed [NUM_W-1:0] num1, num2;
   logic [NUM_W-1:0]        num1_ff, num2_ff;
   logic [23:0]             den_ff;
   logic                    s1_ff, s2_ff, az4_ff, v4_ff;
   logic [1:0]              cnt4_ff;

   logic             d1_valid, d2_valid;
   logic [NUM_W-1:0] q1, q2;
   logic [3:0]       t1;
   logic [0:0]       t2;
   logic [32:0]      r1, r2;

   qrs_pkg::qrs_rsp_type rsp_in, rsp_ff;
   logic                 rsp_valid_ff;

   function automatic logic [32:0] fix_root(input logic [NUM_W-1:0] q, input logic neg);
      logic [32:0] res;
      if (!neg) begin
         if (q > NUM_W'(32'h7FFF_FFFF)) res = {1'b1, 32'h7FFF_FFFF};
         else res = {1'b0, q[31:0]};
      end else begin
         if (q > NUM_W'(32'h8000_0000)) res = {1'b1, 32'h8000_0000};
         else res = {1'b0, 32'(-q[31:0])};
      end
      return res;
   endfunction

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qrs_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // input register and products
   always_comb begin
      bb_in = req_ff.coef_b * req_ff.coef_b;
      ac_in = req_ff.coef_a * req_ff.coef_c;
   end

   always_ff @(posedge clock) begin
      req_ff <= req_item;
      bb1_ff <= bb_in;
      ac1_ff <= ac_in;
      a1_ff  <= req_ff.coef_a;
      b1_ff  <= req_ff.coef_b;
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
         v1_ff <= v0_ff;
      end
   end

   // discriminant and case selection
   always_comb begin
      d_in   = 50'(bb1_ff) - (50'(ac1_ff) <<< 2);
      mag    = d_in[49] ? 50'(-d_in) : 50'(d_in);
      az_in  = (a1_ff == '0);
      one_in = (mag < {10'b0, eps_ff});
      if (az_in) cnt_in = 2'd0;
      else if (one_in) cnt_in = 2'd1;
      else if (d_in[49]) cnt_in = 2'd0;
      else cnt_in = 2'd2;
      x_in = d_in[49] ? '0 : 64'({d_in[48:0], 14'b0});
   end

   always_ff @(posedge clock) begin
      x2_ff   <= x_in;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      cnt2_ff <= cnt_in;
      az2_ff  <= az_in;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   qrs_sqrt #(
      .TAG_W(SQ_TAG_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v2_ff),
      .in_x     (x2_ff),
      .in_tag   ({a2_ff, b2_ff, cnt2_ff, az2_ff}),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_tag  (sq_tag)
   );

   // numerators and magnitudes
   always_comb begin
      {a3, b3, cnt3, az3} = sq_tag;
      bext    = 34'(b3);
      nb      = -(bext <<< 7);
      sx      = {2'b00, sq_root};
      n_plus  = nb + sx;
      n_minus = nb - sx;
      num1    = (cnt3 == 2'd1) ? -(NUM_W'(bext) <<< 15) : (NUM_W'(n_plus) <<< 8);
      num2    = NUM_W'(n_minus) <<< 8;
   end

   always_ff @(posedge clock) begin
      num1_ff <= num1[NUM_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
      num2_ff <= num2[NUM_W-1] ? NUM_W'(-num2) : NUM_W'(num2);
      den_ff  <= a3[23] ? 24'(-a3) : 24'(a3);
      s1_ff   <= num1[NUM_W-1] ^ a3[23];
      s2_ff   <= num2[NUM_W-1] ^ a3[23];
      cnt4_ff <= cnt3;
      az4_ff  <= az3;
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= sq_valid;
      end
   end

   qrs_div #(
      .NUM_W(NUM_W),
      .DEN_W(24),
      .TAG_W(4)
   ) u_div_first (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (num1_ff),
      .in_den   (den_ff),
      .in_tag   ({az4_ff, cnt4_ff, s1_ff}),
      .out_valid(d1_valid),
      .out_quo  (q1),
      .out_tag  (t1)
   );

   qrs_div #(
      .NUM_W(NUM_W),
      .DEN_W(24),
      .TAG_W(1)
   ) u_div_second (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (num2_ff),
      .in_den   (den_ff),
      .in_tag   (s2_ff),
      .out_valid(d2_valid),
      .out_quo  (q2),
      .out_tag  (t2)
   );

   // sign, saturation and result
   always_comb begin
      r1     = fix_root(q1, t1[0]);
      r2     = fix_root(q2, t2[0]);
      rsp_in = '0;
      rsp_in.root_count = t1[2:1];
      case (t1[2:1])
         2'd1: begin
            rsp_in.first_root = r1[31:0];
            rsp_in.status     = r1[32] ? qrs_pkg::STATUS_SAT : qrs_pkg::STATUS_OK;
         end
         2'd2: begin
            rsp_in.first_root  = r1[31:0];
            rsp_in.second_root = r2[31:0];
            rsp_in.status = (r1[32] | r2[32]) ? qrs_pkg::STATUS_SAT : qrs_pkg::STATUS_OK;
         end
         default: begin
            rsp_in.status = t1[3] ? qrs_pkg::STATUS_A_ZERO : qrs_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d1_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `QRS_ASSERT_IMP(a_div_lockstep, d1_valid, d2_valid, "dividers out of step")
   `QRS_ASSERT_NEVER(a_count_range, rsp_valid && rsp_item.root_count == 2'd3, "bad count")
   `QRS_ASSERT_IMP(a_zero_a, rsp_valid && rsp_item.status == qrs_pkg::STATUS_A_ZERO, rsp_item.root_count == 2'd0 && rsp_item.first_root == '0, "a zero with roots")
   `QRS_ASSERT_IMP(a_second_unused, rsp_valid && rsp_item.root_count != 2'd2, rsp_item.second_root == '0, "unused second root set")

endmodule

`default_nettype wire

FILE: sim/quadratic_root_solver_tb.sv
`default_nettype none

module quadratic_root_solver_tb;

   localparam int LATENCY = 79;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  has_exp;
      logic [23:0] a;
      logic [23:0] b;
      logic [23:0] c;
      logic [1:0]  count;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [1:0]  status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   qrs_pkg::qrs_req_type req_item = '0;
   logic rsp_valid;
   qrs_pkg::qrs_rsp_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [qrs_pkg::EPS_W-1:0] csr_wr_data = '0;

   logic [qrs_pkg::EPS_W-1:0] epsilon_copy;
   qrs_pkg::qrs_rsp_type root_queue[$];
   int error_count = 0;
   int cycle_count = 0;
   int sender_idle = 0;

   quadratic_root_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x = x - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp_root(input longint q, inout logic sat);
      if (q > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7FFFFFFF;
      end
      if (q < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return q[31:0];
   endfunction

   function automatic qrs_pkg::qrs_rsp_type solve_roots(input qrs_pkg::qrs_req_type item);
      qrs_pkg::qrs_rsp_type res;
      longint a, b, c, d, s, nb;
      logic [63:0] mag;
      logic sat;
      res = '0;
      sat = 1'b0;
      a = item.coef_a;
      b = item.coef_b;
      c = item.coef_c;
      if (a == 0) begin
         res.status = qrs_pkg::STATUS_A_ZERO;
      end else begin
         d = b * b - 4 * a * c;
         mag = (d < 0) ? -d : d;
         if (mag < {24'd0, epsilon_copy}) begin
            res.root_count = 2'd1;
            res.first_root = clamp_root((-b * 32768) / a, sat);
         end else if (d >= 0) begin
            s = int_sqrt(d << 14);
            nb = -b * 128;
            res.root_count = 2'd2;
            res.first_root = clamp_root(((nb + s) * 256) / a, sat);
            res.second_root = clamp_root(((nb - s) * 256) / a, sat);
         end
         res.status = sat ? qrs_pkg::STATUS_SAT : qrs_pkg::STATUS_OK;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      qrs_pkg::qrs_rsp_type want;
      if (!reset && rsp_valid) begin
         if (root_queue.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = root_queue.pop_front();
            if (rsp_item.root_count !== want.root_count)
               report_mismatch($sformatf("root_count %0d want %0d",
                  rsp_item.root_count, want.root_count));
            if (rsp_item.first_root !== want.first_root)
               report_mismatch($sformatf("first_root %h want %h",
                  rsp_item.first_root, want.first_root));
            if (rsp_item.second_root !== want.second_root)
               report_mismatch($sformatf("second_root %h want %h",
                  rsp_item.second_root, want.second_root));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d want %0d",
                  rsp_item.status, want.status));
         end
      end
   end

   task automatic send_item(input qrs_pkg::qrs_req_type item,
                            input qrs_pkg::qrs_rsp_type want, input bit typed);
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed && want !== solve_roots(item))
         report_mismatch("table row disagrees with predictor");
      root_queue.push_back(solve_roots(item));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (root_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [qrs_pkg::EPS_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      epsilon_copy = value;
      @(posedge clock);
   endtask

   function automatic logic [23:0] random_coef;
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'($urandom_range(255) << 16);
         3: return 24'($signed($urandom_range(2047)) - 1024);
         4: return 24'd0;
         default: return 24'($urandom);
      endcase
   endfunction

   dir_row_type dir_table[16] = '{
      '{2'd1, 24'h0, 24'h010000, 24'h010000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_A_ZERO},
      '{2'd1, 24'h0, 24'h800000, 24'h7FFFFF, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_A_ZERO},
      '{2'd1, 24'h010000, 24'h0, 24'h010000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd1, 24'h010000, 24'h0, 24'h0, 2'd1, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd1, 24'h010000, 24'h0, 24'hFF0000, 2'd2, 32'h00010000, 32'hFFFF0000,
        qrs_pkg::STATUS_OK},
      '{2'd1, 24'h010000, 24'hFE0000, 24'h010000, 2'd1, 32'h00010000, 32'h0,
        qrs_pkg::STATUS_OK},
      '{2'd0, 24'h000001, 24'h7FFFFF, 24'h0, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h000001, 24'h800000, 24'h800000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h800000, 24'h800000, 24'h7FFFFF, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h800000, 24'h7FFFFF, 24'h800000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h000003, 24'h000007, 24'h000002, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK},
      '{2'd0, 24'h020000, 24'h010000, 24'hFF0000, 2'd0, 32'h0, 32'h0, qrs_pkg::STATUS_OK}
   };

   initial begin
      qrs_pkg::qrs_req_type item;
      qrs_pkg::qrs_rsp_type want;
      int phase;
      epsilon_copy = qrs_pkg::EPS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_table[i]) begin
         item.coef_a = dir_table[i].a;
         item.coef_b = dir_table[i].b;
         item.coef_c = dir_table[i].c;
         want = {dir_table[i].count, dir_table[i].r1, dir_table[i].r2,
                 dir_table[i].status};
         send_item(item, want, dir_table[i].has_exp == 2'd1);
      end
      drain();
      write_epsilon('0);
      item = '{24'h010000, 24'h0, 24'h0};
      send_item(item, '0, 1'b0);
      drain();
      write_epsilon({qrs_pkg::EPS_W{1'b1}});
      for (int i = 0; i < 8; i++) begin
         item = '{random_coef(), random_coef(), random_coef()};
         send_item(item, '0, 1'b0);
      end
      drain();
      for (phase = 0; phase < 6; phase++) begin
         sender_idle = (phase < 2) ? 32 : (phase < 4) ? 78 : 0;
         case (phase % 3)
            0: write_epsilon(qrs_pkg::EPS_RESET);
            1: write_epsilon(qrs_pkg::EPS_W'($urandom_range(1 << 20)));
            default: write_epsilon(qrs_pkg::EPS_W'({$urandom, $urandom}));
         endcase
         for (int i = 0; i < 300; i++) begin
            item = '{random_coef(), random_coef(), random_coef()};
            send_item(item, '0, 1'b0);
         end
         drain();
      end
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

`default_nettype wire
